[sv/moving_average_filter_macros.svh]
// assertion macros for the moving average filter
`ifndef MOVING_AVERAGE_FILTER_MACROS_SVH
`define MOVING_AVERAGE_FILTER_MACROS_SVH

// checked on every clock edge outside reset
`define MAVG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define MAVG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/mavg_pkg.sv]
// shared constants and types of the moving average filter
package mavg_pkg;

  // sample and average width
  localparam int SAMPLE_BITS = 12;
  // width of the window depth register
  localparam int DEPTH_W = 5;
  // default ring size
  localparam int MAX_DEPTH_DEF = 16;
  // depth after reset, unless the usable depth limit is smaller
  localparam int DEPTH_RST_MAX = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } mavg_state_t;

endpackage

[sv/moving_average_filter.sv]
// moving average filter: ring store, running sum and bit-serial divider
//
// Boxcar mean over the last window_depth samples.
// Input channel: in_valid / in_stall with the sample word; a word is taken
// when in_valid is high and in_stall is low. Output channel: out_valid /
// out_stall with average and window_full; a word leaves when out_valid is
// high and out_stall is low.
// Until the window has filled once, average is the raw sample; after that it
// is the running sum divided by the depth, truncated.
// Before the window fills, a result goes from the update state straight to
// the done state; once it has filled, the bit-serial restoring divider, one
// quotient bit per cycle, runs in the divide state between them.
// The block takes one word at a time: in_stall is low only in the idle state.
// A finished word waits in the output register while the next one is taken
// in; with that register still full the next result holds in its done state
// until the receiver lifts out_stall.
// Reset (rst, synchronous) sets the depth to its default and clears the
// sum, write index and window-full flag; a cfg_we write does the same with
// the new depth (0 reads as 1, values above the ring size saturate).
// No clearing pass is needed: before the window fills, ring entries read as zero.
`include "moving_average_filter_macros.svh"

module moving_average_filter #(
  parameter int MAX_DEPTH = mavg_pkg::MAX_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mavg_pkg::DEPTH_W-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mavg_pkg::SAMPLE_BITS-1:0] sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mavg_pkg::SAMPLE_BITS-1:0] average,
  output logic                             window_full
);

  import mavg_pkg::*;

  // usable depth is bounded by the ring size and the register width
  localparam int DEPTH_MAXREG = (1 << DEPTH_W) - 1;
  localparam int DEPTH_LIM = (MAX_DEPTH < DEPTH_MAXREG) ? MAX_DEPTH : DEPTH_MAXREG;
  localparam int DEPTH_RST = (DEPTH_LIM < DEPTH_RST_MAX) ? DEPTH_LIM : DEPTH_RST_MAX;
  localparam int IDX_W = (DEPTH_LIM > 1) ? $clog2(DEPTH_LIM) : 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(DEPTH_LIM);
  localparam int REM_W = DEPTH_W + 1;
  localparam int CNT_W = $clog2(SUM_W);

  mavg_state_t state, state_next;

  logic [DEPTH_W-1:0]     depth;
  logic [SUM_W-1:0]       running_sum;
  logic [IDX_W-1:0]       write_index;
  logic                   filled_flag;
  logic [SAMPLE_BITS-1:0] sample_ring [DEPTH_LIM];
  logic [SAMPLE_BITS-1:0] old_entry;
  logic [SAMPLE_BITS-1:0] sample_reg;
  logic [SUM_W-1:0]       div_reg;
  logic [REM_W-2:0]       rem;
  logic [CNT_W-1:0]       cnt;

  logic [DEPTH_W-1:0]     depth_wr;
  logic [SAMPLE_BITS-1:0] old_val;
  logic [SUM_W-1:0]       sum_next;
  logic [DEPTH_W-1:0]     idx_inc;
  logic                   idx_wrap;
  logic [REM_W-1:0]       trial;
  logic [REM_W-1:0]       diff;
  logic                   q_bit;
  logic                   in_take;
  logic                   out_take;
  logic                   load_out;

  // handshakes
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // depth write with zero and saturation handling
  always_comb begin
    depth_wr = cfg_data;
    if (cfg_data == '0) begin
      depth_wr = DEPTH_W'(1);
    end else if (cfg_data > DEPTH_W'(DEPTH_LIM)) begin
      depth_wr = DEPTH_W'(DEPTH_LIM);
    end
  end

  // running sum update and index advance
  always_comb begin
    old_val  = filled_flag ? old_entry : '0;
    sum_next = running_sum - SUM_W'(old_val) + SUM_W'(sample_reg);
    idx_inc  = DEPTH_W'(write_index) + DEPTH_W'(1);
    idx_wrap = (idx_inc == depth);
  end

  // shared compare and subtract of the divider
  always_comb begin
    trial = {rem, div_reg[SUM_W-1]};
    diff  = trial - {1'b0, depth};
    q_bit = (trial >= {1'b0, depth});
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_take) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = (filled_flag || idx_wrap) ? ST_DIVIDE : ST_DONE;
      end
      ST_DIVIDE: begin
        if (cnt == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_UPDATE: in_stall = 1'b1;
      ST_DIVIDE: in_stall = 1'b1;
      ST_DONE:   load_out = !out_valid || !out_stall;
      default:   in_stall = 1'b1;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      depth       <= DEPTH_W'(DEPTH_RST);
      running_sum <= '0;
      write_index <= '0;
      filled_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        depth       <= depth_wr;
        running_sum <= '0;
        write_index <= '0;
        filled_flag <= 1'b0;
      end else if (state == ST_UPDATE) begin
        running_sum <= sum_next;
        write_index <= idx_wrap ? '0 : idx_inc[IDX_W-1:0];
        if (idx_wrap) filled_flag <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ring store: oldest entry read at accept, new sample written on update
  always_ff @(posedge clk) begin
    if (in_take) old_entry <= sample_ring[write_index];
    if (state == ST_UPDATE) sample_ring[write_index] <= sample_reg;
  end

  // datapath and output word
  always_ff @(posedge clk) begin
    if (in_take) sample_reg <= sample;
    if (state == ST_UPDATE) begin
      div_reg <= sum_next;
      rem     <= '0;
      cnt     <= CNT_W'(SUM_W - 1);
    end else if (state == ST_DIVIDE) begin
      div_reg <= {div_reg[SUM_W-2:0], q_bit};
      rem     <= q_bit ? diff[REM_W-2:0] : trial[REM_W-2:0];
      cnt     <= cnt - CNT_W'(1);
    end
    if (load_out) begin
      average     <= filled_flag ? div_reg[SAMPLE_BITS-1:0] : sample_reg;
      window_full <= filled_flag;
    end
  end

  // checks
  `MAVG_ASSERT(a_out_from_done, $rose(out_valid) |-> $past(state) == ST_DONE, "no result")
  `MAVG_ASSERT(a_rem_below_depth, state == ST_DIVIDE |-> rem < depth, "remainder not below depth")
  `MAVG_ASSERT(a_index_in_window, DEPTH_W'(write_index) < depth, "write index out of window")
  `MAVG_ASSERT(a_accept_starts_update, in_take |=> state == ST_UPDATE, "accept without update")
  `MAVG_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && !filled_flag, "reset left flags set")

endmodule

[test/tb_moving_average_filter.sv]
// testbench for the moving average filter: predicted window means checked on the output channel
module tb_moving_average_filter;
  import mavg_pkg::*;

  localparam int RING_DEPTH = MAX_DEPTH_DEF;
  localparam int SUM_BITS = 16;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  // settling wait before a depth write and at the end of the test
  localparam int SETTLE_CYCLES = SUM_BITS + 12;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD = 80;

  // predicts the average and the window-full flag for every accepted sample
  class window_mean_board;
    logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
    logic [SUM_BITS-1:0] window_sum;
    int unsigned wr_pos;
    int unsigned depth;
    bit filled;
    logic [SAMPLE_BITS-1:0] pending_avg [$];
    bit pending_full [$];
    int errors;

    function new();
      errors = 0;
      depth = DEPTH_RST_MAX;
      clear_window();
    endfunction

    function void clear_window();
      foreach (ring[i]) ring[i] = '0;
      window_sum = '0;
      wr_pos = 0;
      filled = 0;
    endfunction

    // depth register write: zero reads as one, large values saturate
    function void set_depth(logic [DEPTH_W-1:0] value);
      if (value == 0) depth = 1;
      else if (value > RING_DEPTH) depth = RING_DEPTH;
      else depth = int'(value);
      clear_window();
    endfunction

    // accepted sample: update ring and sum, queue the expected word
    function void note_sample(logic [SAMPLE_BITS-1:0] s);
      int unsigned pos;
      logic [SUM_BITS-1:0] mean;
      pos = (wr_pos >= depth) ? 0 : wr_pos;
      window_sum = window_sum - SUM_BITS'(ring[pos]);
      ring[pos] = s;
      window_sum = window_sum + SUM_BITS'(s);
      pos++;
      if (pos == depth) begin
        pos = 0;
        filled = 1;
      end
      wr_pos = pos;
      mean = SUM_BITS'(window_sum / depth);
      pending_avg.push_back(filled ? mean[SAMPLE_BITS-1:0] : s);
      pending_full.push_back(filled);
    endfunction

    // accepted result word: compare with the oldest expectation
    function void check_result(logic [SAMPLE_BITS-1:0] avg, logic full);
      logic [SAMPLE_BITS-1:0] exp_avg;
      bit exp_full;
      if (pending_avg.size() == 0) begin
        report($sformatf("%0t: unexpected word, average %0d window_full %0b",
                         $time, avg, full));
      end else begin
        exp_avg = pending_avg.pop_front();
        exp_full = pending_full.pop_front();
        if (avg !== exp_avg)
          report($sformatf("%0t: average mismatch, expected %0d actual %0d",
                           $time, exp_avg, avg));
        if (full !== exp_full)
          report($sformatf("%0t: window_full mismatch, expected %0b actual %0b",
                           $time, exp_full, full));
      end
    endfunction

    // count and print every failure
    function void report(string msg);
      errors++;
      $display("%s", msg);
    endfunction

    function int pending();
      return pending_avg.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [DEPTH_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SAMPLE_BITS-1:0] average;
  logic window_full;

  window_mean_board board = new();
  bit no_idle = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int samples_sent = 0;

  moving_average_filter u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .average(average),
    .window_full(window_full)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("[moving_average_filter] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, two long hold-offs
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (results_seen == 30 || results_seen == 250) gap = LONG_HOLD;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_result(average, window_full);
      results_seen++;
    end
  end

  // edge extremes and random values, every bit both ways
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] one_hot;
    one_hot = SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SAMPLE_MAX;
      2: return one_hot;
      3: return ~one_hot;
      default: return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    endcase
  endfunction

  // offer one sample word and wait for it to be taken
  task automatic send_sample(logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (in_stall);
    board.note_sample(s);
    samples_sent++;
  endtask

  // drain all results, let the block settle, then write the depth
  task automatic write_depth(logic [DEPTH_W-1:0] value);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_depth(value);
  endtask

  // stimulus
  initial begin
    int count;
    logic [DEPTH_W-1:0] depth_val;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // full-scale window at reset depth, then a drop and bit patterns
    repeat (17) send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(SAMPLE_BITS'(12'hAAA));
    send_sample(SAMPLE_BITS'(12'h555));
    // depth zero reads as one
    write_depth('0);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    // depth above ring size saturates
    write_depth('1);
    repeat (3) send_sample(pick_sample());

    // long first phase so the long receiver hold-off backs up the input
    write_depth(DEPTH_W'(4));
    repeat (60) send_sample(pick_sample());

    // random phases over several depths
    while (samples_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: depth_val = '0;
        1: depth_val = DEPTH_W'(1);
        2: depth_val = DEPTH_W'(RING_DEPTH);
        3: depth_val = '1;
        default: depth_val = DEPTH_W'($urandom_range(0, (1 << DEPTH_W) - 1));
      endcase
      write_depth(depth_val);
      no_idle = ($urandom_range(0, 3) == 0);
      count = $urandom_range(5, 50);
      repeat (count) send_sample(pick_sample());
    end
    no_idle = 0;
    in_valid <= 1'b0;

    // wait for the last results, then a settling window
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("[moving_average_filter] OK");
    end else begin
      $display("[moving_average_filter] ERROR");
    end
    $finish;
  end

endmodule
